@@ hdl/kcpl_pkg.sv @@
package kcpl_pkg;

  // table geometry
  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = 8;
  localparam int unsigned CountW     = 9;
  localparam int unsigned CodeW      = 20;
  localparam int unsigned CodeDigits = 6;
  localparam int unsigned DigitW     = 3;

  localparam logic [CountW-1:0] CountReset = 9'd214;
  localparam logic [CountW-1:0] CountMax   = 9'd256;
  // smallest value that already has the full digit count
  localparam logic [CodeW-1:0]  PadLimit   = 20'd100000;
  localparam logic [DigitW-1:0] DigitLast  = 3'(CodeDigits - 1);

  // x / 10 as (x * Div10Mult) >> Div10Shift, exact for every 20-bit x
  localparam logic [CodeW-1:0] Div10Mult  = 20'd838861;
  localparam int unsigned      Div10Shift = 23;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } kcpl_op_e;

  typedef enum logic [1:0] {
    EMIT_MISS   = 2'd0,
    EMIT_EXACT  = 2'd1,
    EMIT_PREFIX = 2'd2
  } kcpl_emit_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PROBE,
    ST_PRE_LOAD,
    ST_PREFIX,
    ST_EMIT
  } kcpl_state_e;

  typedef struct packed {
    logic              operation;
    logic [AddrW-1:0]  entry_index;
    logic [CodeW-1:0]  entry_code;
    logic [CodeW-1:0]  query_number;
  } kcpl_req_t;

  typedef struct packed {
    logic             match_valid;
    logic             exact_hit;
    logic [AddrW-1:0] match_index;
  } kcpl_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic       wr_en;
    logic       capture;
    logic       pad_step;
    logic       bound_upd;
    logic       rd_en;
    logic       rd_left;
    logic       pre_init;
    logic       pre_step;
    logic       emit;
    kcpl_emit_e emit_kind;
  } kcpl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pad_done;
    logic range_open;
    logic left_in_table;
    logic probe_eq;
    logic pre_last;
  } kcpl_sts_t;

  function automatic logic [CodeW-1:0] div10(input logic [CodeW-1:0] x);
    logic [2*CodeW-1:0] prod;
    prod = {{CodeW{1'b0}}, x} * {{CodeW{1'b0}}, Div10Mult};
    return CodeW'(prod >> Div10Shift);
  endfunction

endpackage

@@ hdl/kcpl_ctrl.sv @@
module kcpl_ctrl
  import kcpl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      operation_i,
  input  kcpl_sts_t sts_i,
  output kcpl_cmd_t cmd_o,
  output logic      busy
);

  kcpl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && (operation_i == OP_LOOKUP)) state_d = ST_PAD;
      end
      ST_PAD, ST_PROBE: begin
        if (state_q == ST_PROBE && sts_i.probe_eq) begin
          state_d = ST_IDLE;
        end else if (state_q == ST_PAD && !sts_i.pad_done) begin
          state_d = ST_PAD;
        end else if (sts_i.range_open) begin
          state_d = ST_PROBE;
        end else if (sts_i.left_in_table) begin
          state_d = ST_PRE_LOAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PRE_LOAD: state_d = ST_PREFIX;
      ST_PREFIX: begin
        if (sts_i.pre_last) state_d = ST_EMIT;
      end
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation_i == OP_LOOKUP) cmd_o.capture = 1'b1;
          else                          cmd_o.wr_en   = 1'b1;
        end
      end
      ST_PAD, ST_PROBE: begin
        cmd_o.bound_upd = (state_q == ST_PROBE);
        if (state_q == ST_PROBE && sts_i.probe_eq) begin
          cmd_o.bound_upd = 1'b0;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EMIT_EXACT;
        end else if (state_q == ST_PAD && !sts_i.pad_done) begin
          cmd_o.pad_step = 1'b1;
        end else if (sts_i.range_open) begin
          cmd_o.rd_en = 1'b1;
        end else if (sts_i.left_in_table) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_left = 1'b1;
        end else begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EMIT_MISS;
        end
      end
      ST_PRE_LOAD: cmd_o.pre_init = 1'b1;
      ST_PREFIX:   cmd_o.pre_step = 1'b1;
      ST_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = EMIT_PREFIX;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ hdl/kcpl_dp.sv @@
module kcpl_dp
  import kcpl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kcpl_req_t         req_i,
  input  kcpl_cmd_t         cmd_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  output kcpl_sts_t         sts_o,
  output kcpl_rsp_t         result_o,
  output logic              done_o
);

  logic [CodeW-1:0]  mem [TableDepth];
  logic [CodeW-1:0]  rd_data_q;

  logic [CountW-1:0] entries_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] left_q, hi_q;
  logic [CountW-1:0] left_nxt, hi_nxt;
  logic [AddrW-1:0]  mid_q, mid_c, rd_addr;
  logic [CountW:0]   mid_sum;
  logic [CodeW-1:0]  query_q, query_x10;

  logic [CodeW-1:0]  qq_q, ee_q, qq_div, ee_div;
  logic [CodeW+3:0]  qq_div_x10;
  logic [DigitW-1:0] dig_q;
  logic              pre_hit_q;

  logic              done_q;
  kcpl_rsp_t         rsp_q;

  // register port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= CountReset;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  // code table
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[req_i.entry_index] <= req_i.entry_code;
    if (cmd_i.rd_en) rd_data_q <= mem[rd_addr];
  end

  // search bounds, updated on the probe result
  always_comb begin
    left_nxt = left_q;
    hi_nxt   = hi_q;
    if (cmd_i.bound_upd) begin
      if (query_q < rd_data_q) hi_nxt   = {1'b0, mid_q};
      else                     left_nxt = {1'b0, mid_q} + 9'd1;
    end
  end

  assign mid_sum   = {1'b0, left_nxt} + {1'b0, hi_nxt} - 10'd1;
  assign mid_c     = mid_sum[AddrW:1];
  assign rd_addr   = cmd_i.rd_left ? left_nxt[AddrW-1:0] : mid_c;
  assign query_x10 = {query_q[CodeW-4:0], 3'b000} + {query_q[CodeW-2:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      query_q <= req_i.query_number;
      count_q <= (entries_q > CountMax) ? CountMax : entries_q;
      left_q  <= '0;
      hi_q    <= (entries_q > CountMax) ? CountMax : entries_q;
    end else begin
      if (cmd_i.pad_step) query_q <= query_x10;
      if (cmd_i.bound_upd) begin
        left_q <= left_nxt;
        hi_q   <= hi_nxt;
      end
    end
    if (cmd_i.rd_en && !cmd_i.rd_left) mid_q <= mid_c;
  end

  // prefix check, one decimal digit per cycle from the low end;
  // the highest zero digit of the query decides
  assign qq_div     = div10(qq_q);
  assign ee_div     = div10(ee_q);
  assign qq_div_x10 = {1'b0, qq_div, 3'b000} + {3'b000, qq_div, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.pre_init) begin
      qq_q      <= query_q;
      ee_q      <= rd_data_q;
      pre_hit_q <= (query_q == rd_data_q);
      dig_q     <= '0;
    end else if (cmd_i.pre_step) begin
      if (dig_q == DigitLast) begin
        if (qq_q == '0) pre_hit_q <= 1'b1;
      end else begin
        if (qq_div_x10 == {4'b0000, qq_q}) pre_hit_q <= (qq_div == ee_div);
        qq_q <= qq_div;
        ee_q <= ee_div;
      end
      dig_q <= dig_q + 3'd1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.emit_kind)
        EMIT_EXACT: begin
          rsp_q.match_valid <= 1'b1;
          rsp_q.exact_hit   <= 1'b1;
          rsp_q.match_index <= mid_q;
        end
        EMIT_PREFIX: begin
          rsp_q.match_valid <= pre_hit_q;
          rsp_q.exact_hit   <= 1'b0;
          rsp_q.match_index <= pre_hit_q ? left_q[AddrW-1:0] : '0;
        end
        default: begin
          rsp_q <= '0;
        end
      endcase
    end
  end

  assign sts_o.pad_done      = (query_q == '0) || (query_q >= PadLimit);
  assign sts_o.range_open    = (left_nxt < hi_nxt);
  assign sts_o.left_in_table = (left_nxt < count_q);
  assign sts_o.probe_eq      = (rd_data_q == query_q);
  assign sts_o.pre_last      = (dig_q == DigitLast);

  assign result_o = rsp_q;
  assign done_o   = done_q;

endmodule

@@ hdl/keypad_code_prefix_lookup.sv @@
// load transaction: taken while busy is low, gives no result; busy stays low
// lookup transaction: P pad steps and K table probes to an exact hit, a miss or a prefix check
//   P = zero digits appended (0..5), K = table probes (up to 9 for 256 entries)
// one probe per cycle on the single read port of the code table; prefix check is one digit a cycle
// result strobe done_o lasts one cycle and cannot be stalled; busy returns low with it
// reset clears the controller, the strobe and entries_in_use (214); table contents stay undefined
module keypad_code_prefix_lookup
  import kcpl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // command side: accepted when start is high and busy is low
  input  logic              start,
  input  kcpl_req_t         req_i,
  output logic              busy,
  // entries_in_use register, write only
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  // result side: one transaction per lookup, valid while done_o is high
  output kcpl_rsp_t         result_o,
  output logic              done_o
);

  kcpl_cmd_t cmd;
  kcpl_sts_t sts;

  // controller: sequences padding, the binary search and the prefix check
  kcpl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (req_i.operation),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // datapath: code table, search bounds, digit unit and result register
  kcpl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_o       (sts),
    .result_o    (result_o),
    .done_o      (done_o)
  );

endmodule
